### sv/mono_framebuffer_draw_engine_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the framebuffer draw engine
// Concurrent checks, compiled away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef MONO_FRAMEBUFFER_DRAW_ENGINE_ASSERT_SVH
`define MONO_FRAMEBUFFER_DRAW_ENGINE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Antecedent implies consequent in the same cycle.
`define MFDE_ASSERT_IMP(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("mfde check failed: implication");

// Condition never holds.
`define MFDE_ASSERT_NEVER(name, ck, rn, cond) \
  name: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
    else $error("mfde check failed: forbidden condition");

`else

`define MFDE_ASSERT_IMP(name, ck, rn, ante, cons)
`define MFDE_ASSERT_NEVER(name, ck, rn, cond)

`endif

`endif

### sv/mfde_pkg.sv
// ----------------------------------------------------------------------------
// mfde_pkg
// Shared codes, command word and state types of the framebuffer draw engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mfde_pkg;

  // Operation codes on the input channel
  localparam logic [2:0] OP_POINT = 3'd0;
  localparam logic [2:0] OP_LINE  = 3'd1;
  localparam logic [2:0] OP_FILL  = 3'd2;
  localparam logic [2:0] OP_CLEAR = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  localparam logic [7:0] TOP_ROW_MASK = 8'h80;
  localparam int         QUEUE_DEPTH  = 2;
  localparam int         ERR_W        = 10;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_POINT,
    CMD_LINE,
    CMD_FILL,
    CMD_CLEAR,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                kind;
    logic [6:0]               x0;
    logic [5:0]               y0;
    logic [6:0]               x1;
    logic [5:0]               y1;
    logic                     paint;
    logic [7:0]               fill_value;
    logic                     steep;
    logic                     sx_neg;
    logic                     sy_neg;
    logic [6:0]               major;
    logic [6:0]               minor;
    logic signed [ERR_W-1:0]  err0;
  } draw_cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_SWEEP,
    ST_DONE
  } back_state_t;

  typedef struct packed {
    logic init_busy;
    logic pop;
  } back_status_t;

endpackage

`default_nettype wire

### sv/mono_framebuffer_draw_engine.sv
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine
// One-bit framebuffer drawing engine: points, lines, filled rectangles,
// full clears and byte reads on a paged column-byte store.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  operation, coordinates, paint
//   out_     output     out_valid/out_stall  read_data (one word per command)
//
// Commands run one at a time in the back end; a two-word queue lets the
// input side keep taking words while a command runs or a result waits.
// Each pixel is a RAM read then a write; a line walks major+1 pixels, a
// fill each clipped pixel; a clear sweeps every address; a read one byte.
// After reset the RAM is zeroed over all DEPTH addresses (384 by default),
// with in_stall high; an output stall holds the result and then the queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mono_framebuffer_draw_engine_assert.svh"

module mono_framebuffer_draw_engine #(
  parameter int SCREEN_WIDTH  = 96,
  parameter int SCREEN_HEIGHT = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] in_operation,
  input  wire logic [6:0] in_x_start,
  input  wire logic [5:0] in_y_start,
  input  wire logic [6:0] in_x_end,
  input  wire logic [5:0] in_y_end,
  input  wire logic [7:0] in_paint_value,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_read_data
);

  mfde_pkg::back_status_t back_st;
  mfde_pkg::draw_cmd_t    push_cmd;
  mfde_pkg::draw_cmd_t    head_cmd;
  logic                   push;
  logic                   q_full;
  logic                   q_valid;

  mfde_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_x_start     (in_x_start),
    .in_y_start     (in_y_start),
    .in_x_end       (in_x_end),
    .in_y_end       (in_y_end),
    .in_paint_value (in_paint_value),
    .q_full         (q_full),
    .back_st        (back_st),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  mfde_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (back_st.pop),
    .valid    (q_valid),
    .head_cmd (head_cmd)
  );

  mfde_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_cmd         (head_cmd),
    .back_st       (back_st),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data)
  );

  `MFDE_ASSERT_NEVER(a_no_push_when_full, clk, rst_n, push && q_full)
  `MFDE_ASSERT_IMP(a_pop_needs_cmd, clk, rst_n, back_st.pop, q_valid)
  `MFDE_ASSERT_IMP(a_no_result_in_init, clk, rst_n, back_st.init_busy, !out_valid)
  `MFDE_ASSERT_IMP(a_queue_empty_after_init, clk, rst_n, $fell(back_st.init_busy), !q_valid)

endmodule

`default_nettype wire

### sv/mfde_ram.sv
// ----------------------------------------------------------------------------
// mfde_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mfde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 384
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### sv/mfde_front.sv
// ----------------------------------------------------------------------------
// mfde_front
// Accepts commands, clips them against the screen and sets up line terms.
// ----------------------------------------------------------------------------
`default_nettype none

module mfde_front #(
  parameter int SCREEN_WIDTH  = 96,
  parameter int SCREEN_HEIGHT = 32
) (
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [2:0]           in_operation,
  input  wire logic [6:0]           in_x_start,
  input  wire logic [5:0]           in_y_start,
  input  wire logic [6:0]           in_x_end,
  input  wire logic [5:0]           in_y_end,
  input  wire logic [7:0]           in_paint_value,
  input  wire logic                 q_full,
  input  wire mfde_pkg::back_status_t back_st,
  output logic                      push,
  output mfde_pkg::draw_cmd_t       push_cmd
);

  localparam logic [7:0] X_LIM    = 8'(SCREEN_WIDTH);
  localparam logic [6:0] Y_LIM    = 7'(SCREEN_HEIGHT);
  localparam logic [6:0] X_MAX    = 7'(SCREEN_WIDTH - 1);
  localparam logic [5:0] Y_MAX    = 6'(SCREEN_HEIGHT - 1);

  logic       start_on;
  logic [6:0] ax;
  logic [6:0] ay;
  logic       steep;
  logic [6:0] major;
  logic [6:0] minor;
  logic [6:0] x_clip;
  logic [5:0] y_clip;
  logic       fill_empty;

  assign in_stall = q_full || back_st.init_busy;
  assign push     = in_valid && !in_stall;

  always_comb begin
    start_on   = ({1'b0, in_x_start} < X_LIM) && ({1'b0, in_y_start} < Y_LIM);
    ax         = (in_x_end >= in_x_start) ? (in_x_end - in_x_start)
                                          : (in_x_start - in_x_end);
    ay         = {1'b0, (in_y_end >= in_y_start) ? (in_y_end - in_y_start)
                                                 : (in_y_start - in_y_end)};
    steep      = ay > ax;
    major      = steep ? ay : ax;
    minor      = steep ? ax : ay;
    x_clip     = (in_x_end > X_MAX) ? X_MAX : in_x_end;
    y_clip     = (in_y_end > Y_MAX) ? Y_MAX : in_y_end;
    fill_empty = (in_x_start > x_clip) || (in_y_start > y_clip);
  end

  always_comb begin
    push_cmd            = '0;
    push_cmd.x0         = in_x_start;
    push_cmd.y0         = in_y_start;
    push_cmd.x1         = in_x_end;
    push_cmd.y1         = in_y_end;
    push_cmd.paint      = (in_paint_value != 8'd0);
    push_cmd.fill_value = in_paint_value;
    push_cmd.steep      = steep;
    push_cmd.sx_neg     = in_x_end < in_x_start;
    push_cmd.sy_neg     = in_y_end < in_y_start;
    push_cmd.major      = major;
    push_cmd.minor      = minor;
    push_cmd.err0       = mfde_pkg::ERR_W'({minor, 1'b0}) - mfde_pkg::ERR_W'(major);
    unique case (in_operation)
      mfde_pkg::OP_POINT: push_cmd.kind = start_on ? mfde_pkg::CMD_POINT : mfde_pkg::CMD_NOP;
      mfde_pkg::OP_LINE:  push_cmd.kind = mfde_pkg::CMD_LINE;
      mfde_pkg::OP_FILL: begin
        // clip the far corner to the screen so the walk stays on it
        push_cmd.kind = fill_empty ? mfde_pkg::CMD_NOP : mfde_pkg::CMD_FILL;
        push_cmd.x1   = x_clip;
        push_cmd.y1   = y_clip;
      end
      mfde_pkg::OP_CLEAR: push_cmd.kind = mfde_pkg::CMD_CLEAR;
      mfde_pkg::OP_READ:  push_cmd.kind = start_on ? mfde_pkg::CMD_READ : mfde_pkg::CMD_NOP;
      default:            push_cmd.kind = mfde_pkg::CMD_NOP;
    endcase
  end

endmodule

`default_nettype wire

### sv/mfde_queue.sv
// ----------------------------------------------------------------------------
// mfde_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module mfde_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire mfde_pkg::draw_cmd_t push_cmd,
  output logic                     full,
  input  wire logic                pop,
  output logic                     valid,
  output mfde_pkg::draw_cmd_t      head_cmd
);

  localparam int AW = (mfde_pkg::QUEUE_DEPTH > 1) ? $clog2(mfde_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(mfde_pkg::QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(mfde_pkg::QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT  = AW'(mfde_pkg::QUEUE_DEPTH - 1);

  mfde_pkg::draw_cmd_t entries_r [mfde_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full     = (count_r == FULL_COUNT);
  assign valid    = (count_r != '0);
  assign head_cmd = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

### sv/mfde_back.sv
// ----------------------------------------------------------------------------
// mfde_back
// Executes commands on the framebuffer RAM: pixel walks with read-modify-write,
// clear sweeps, byte reads, and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mfde_back #(
  parameter int SCREEN_WIDTH  = 96,
  parameter int SCREEN_HEIGHT = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_valid,
  input  wire mfde_pkg::draw_cmd_t   q_cmd,
  output mfde_pkg::back_status_t     back_st,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [7:0]                 out_read_data
);

  localparam int DEPTH  = SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [7:0] X_LIM = 8'(SCREEN_WIDTH);
  localparam logic [6:0] Y_LIM = 7'(SCREEN_HEIGHT);

  mfde_pkg::back_state_t state_r, state_nxt;
  mfde_pkg::cmd_kind_t   kind_r, kind_nxt;

  logic                             paint_r, paint_nxt;
  logic [7:0]                       fill_r, fill_nxt;
  logic                             steep_r, steep_nxt;
  logic                             sxn_r, sxn_nxt;
  logic                             syn_r, syn_nxt;
  logic [6:0]                       major_r, major_nxt;
  logic [6:0]                       minor_r, minor_nxt;
  logic [6:0]                       x0_r, x0_nxt;
  logic [6:0]                       x1_r, x1_nxt;
  logic [5:0]                       y1_r, y1_nxt;
  logic [6:0]                       px_r, px_nxt;
  logic [5:0]                       py_r, py_nxt;
  logic signed [mfde_pkg::ERR_W-1:0] err_r, err_nxt;
  logic [6:0]                       rem_r, rem_nxt;
  logic [ADDR_W-1:0]                sweep_r, sweep_nxt;
  logic [7:0]                       result_r, result_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [7:0]                       out_data_r, out_data_nxt;

  logic                             on_screen;
  logic [ADDR_W-1:0]                pix_addr;
  logic [7:0]                       pix_mask;
  logic [7:0]                       wr_byte;
  logic                             out_free;
  logic                             sweep_last;

  logic                             adv_last;
  logic                             err_ge;
  logic                             x_step;
  logic                             y_step;
  logic [6:0]                       adv_px;
  logic [5:0]                       adv_py;
  logic signed [mfde_pkg::ERR_W-1:0] adv_err;
  logic [6:0]                       adv_rem;

  logic                             ram_we;
  logic [ADDR_W-1:0]                ram_waddr;
  logic [7:0]                       ram_wdata;
  logic [7:0]                       ram_rdata;

  mfde_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (pix_addr),
    .rdata (ram_rdata)
  );

  // pixel geometry: page of eight rows times width plus column
  always_comb begin
    on_screen  = ({1'b0, px_r} < X_LIM) && ({1'b0, py_r} < Y_LIM);
    pix_addr   = ADDR_W'(py_r[5:3]) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(px_r);
    pix_mask   = mfde_pkg::TOP_ROW_MASK >> py_r[2:0];
    wr_byte    = paint_r ? (ram_rdata | pix_mask) : (ram_rdata & ~pix_mask);
    out_free   = !out_valid_r || !out_stall;
    sweep_last = (sweep_r == LAST_ADDR);
  end

  // walker step for the current command
  always_comb begin
    err_ge  = !err_r[mfde_pkg::ERR_W-1];
    x_step  = steep_r ? err_ge : 1'b1;
    y_step  = steep_r ? 1'b1 : err_ge;
    adv_px  = px_r;
    adv_py  = py_r;
    adv_err = err_r;
    adv_rem = rem_r;
    adv_last = 1'b1;
    unique case (kind_r)
      mfde_pkg::CMD_LINE: begin
        adv_last = (rem_r == 7'd0);
        if (x_step) begin
          adv_px = sxn_r ? (px_r - 7'd1) : (px_r + 7'd1);
        end
        if (y_step) begin
          adv_py = syn_r ? (py_r - 6'd1) : (py_r + 6'd1);
        end
        adv_err = err_r + mfde_pkg::ERR_W'({minor_r, 1'b0})
                - (err_ge ? mfde_pkg::ERR_W'({major_r, 1'b0}) : '0);
        adv_rem = rem_r - 7'd1;
      end
      mfde_pkg::CMD_FILL: begin
        adv_last = (px_r == x1_r) && (py_r == y1_r);
        if (px_r == x1_r) begin
          adv_px = x0_r;
          adv_py = py_r + 6'd1;
        end else begin
          adv_px = px_r + 7'd1;
        end
      end
      default: adv_last = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mfde_pkg::ST_INIT: begin
        if (sweep_last) state_nxt = mfde_pkg::ST_IDLE;
      end
      mfde_pkg::ST_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.kind)
            mfde_pkg::CMD_NOP:   state_nxt = mfde_pkg::ST_DONE;
            mfde_pkg::CMD_CLEAR: state_nxt = mfde_pkg::ST_SWEEP;
            default:             state_nxt = mfde_pkg::ST_PIX_RD;
          endcase
        end
      end
      mfde_pkg::ST_PIX_RD: begin
        if (on_screen) begin
          state_nxt = mfde_pkg::ST_PIX_WR;
        end else if (adv_last) begin
          state_nxt = mfde_pkg::ST_DONE;
        end
      end
      mfde_pkg::ST_PIX_WR: begin
        if (kind_r == mfde_pkg::CMD_READ || adv_last) begin
          state_nxt = mfde_pkg::ST_DONE;
        end else begin
          state_nxt = mfde_pkg::ST_PIX_RD;
        end
      end
      mfde_pkg::ST_SWEEP: begin
        if (sweep_last) state_nxt = mfde_pkg::ST_DONE;
      end
      mfde_pkg::ST_DONE: begin
        if (out_free) state_nxt = mfde_pkg::ST_IDLE;
      end
      default: state_nxt = mfde_pkg::ST_INIT;
    endcase
  end

  // datapath and outputs
  always_comb begin
    kind_nxt      = kind_r;
    paint_nxt     = paint_r;
    fill_nxt      = fill_r;
    steep_nxt     = steep_r;
    sxn_nxt       = sxn_r;
    syn_nxt       = syn_r;
    major_nxt     = major_r;
    minor_nxt     = minor_r;
    x0_nxt        = x0_r;
    x1_nxt        = x1_r;
    y1_nxt        = y1_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    err_nxt       = err_r;
    rem_nxt       = rem_r;
    sweep_nxt     = sweep_r;
    result_nxt    = result_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = pix_addr;
    ram_wdata     = wr_byte;
    back_st       = '0;
    back_st.init_busy = (state_r == mfde_pkg::ST_INIT);

    unique case (state_r)
      mfde_pkg::ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_r;
        ram_wdata = 8'd0;
        sweep_nxt = sweep_r + ADDR_W'(1);
      end
      mfde_pkg::ST_IDLE: begin
        if (q_valid) begin
          back_st.pop = 1'b1;
          kind_nxt    = q_cmd.kind;
          paint_nxt   = q_cmd.paint;
          fill_nxt    = q_cmd.fill_value;
          steep_nxt   = q_cmd.steep;
          sxn_nxt     = q_cmd.sx_neg;
          syn_nxt     = q_cmd.sy_neg;
          major_nxt   = q_cmd.major;
          minor_nxt   = q_cmd.minor;
          x0_nxt      = q_cmd.x0;
          x1_nxt      = q_cmd.x1;
          y1_nxt      = q_cmd.y1;
          px_nxt      = q_cmd.x0;
          py_nxt      = q_cmd.y0;
          err_nxt     = q_cmd.err0;
          rem_nxt     = q_cmd.major;
          sweep_nxt   = '0;
          result_nxt  = 8'd0;
        end
      end
      mfde_pkg::ST_PIX_RD: begin
        // off-screen pixel: skip straight to the next one
        if (!on_screen && !adv_last) begin
          px_nxt  = adv_px;
          py_nxt  = adv_py;
          err_nxt = adv_err;
          rem_nxt = adv_rem;
        end
      end
      mfde_pkg::ST_PIX_WR: begin
        if (kind_r == mfde_pkg::CMD_READ) begin
          result_nxt = ram_rdata;
        end else begin
          ram_we = 1'b1;
          if (!adv_last) begin
            px_nxt  = adv_px;
            py_nxt  = adv_py;
            err_nxt = adv_err;
            rem_nxt = adv_rem;
          end
        end
      end
      mfde_pkg::ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_r;
        ram_wdata = fill_r;
        sweep_nxt = sweep_r + ADDR_W'(1);
      end
      mfde_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = result_r;
        end
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mfde_pkg::ST_INIT;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    paint_r    <= paint_nxt;
    fill_r     <= fill_nxt;
    steep_r    <= steep_nxt;
    sxn_r      <= sxn_nxt;
    syn_r      <= syn_nxt;
    major_r    <= major_nxt;
    minor_r    <= minor_nxt;
    x0_r       <= x0_nxt;
    x1_r       <= x1_nxt;
    y1_r       <= y1_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    err_r      <= err_nxt;
    rem_r      <= rem_nxt;
    result_r   <= result_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

endmodule

`default_nettype wire
